// ===== hdl/cref_pkg.sv =====
// Shared types and constants for the clipped rectangle fill engine.
// Depends on nothing; every other file imports it.
package cref_pkg;

    localparam int CRD_W      = 18;   // signed coordinate math width
    localparam int OFFS_W     = 28;
    localparam int BPP_SHIFT  = 2;    // four bytes per pixel
    localparam int APB_ADDR_W = 4;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_IDLE    = 2'd2;
    localparam logic [1:0] ST_RESTART = 2'd3;

    localparam logic [2:0] FMT_ARGB = 3'd1;
    localparam logic [2:0] FMT_XRGB = 3'd2;
    localparam logic [2:0] FMT_BGRA = 3'd3;
    localparam logic [2:0] FMT_BGRX = 3'd4;

    localparam logic [1:0] REG_SURF_W = 2'd0;
    localparam logic [1:0] REG_SURF_H = 2'd1;
    localparam logic [1:0] REG_STRIDE = 2'd2;
    localparam logic [1:0] REG_FORMAT = 2'd3;

    typedef struct packed {
        logic [12:0] surface_width;
        logic [12:0] surface_height;
        logic [15:0] row_stride_bytes;
        logic [2:0]  pixel_format;
    } cfg_t;

    typedef struct packed {
        logic               req_type;
        logic signed [15:0] rect_left;
        logic signed [15:0] rect_top;
        logic signed [15:0] rect_width;
        logic signed [15:0] rect_height;
        logic [31:0]        fill_colour;
    } in_word_t;

    typedef struct packed {
        logic              write_valid;
        logic [OFFS_W-1:0] byte_offset;
        logic [31:0]       pixel_data;
        logic              last;
        logic [1:0]        status;
    } out_word_t;

endpackage

// ===== hdl/cref_apb_regs.sv =====
// APB configuration registers: surface size, row stride, pixel format.
// Depends on cref_pkg.
module cref_apb_regs import cref_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SURF_W: cfg_reg.surface_width    <= pwdata[12:0];
                REG_SURF_H: cfg_reg.surface_height   <= pwdata[12:0];
                REG_STRIDE: cfg_reg.row_stride_bytes <= pwdata[15:0];
                REG_FORMAT: cfg_reg.pixel_format     <= pwdata[2:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SURF_W: prdata = {19'd0, cfg_reg.surface_width};
            REG_SURF_H: prdata = {19'd0, cfg_reg.surface_height};
            REG_STRIDE: prdata = {16'd0, cfg_reg.row_stride_bytes};
            REG_FORMAT: prdata = {29'd0, cfg_reg.pixel_format};
            default:    prdata = '0;
        endcase
    end

endmodule

// ===== hdl/cref_clip_pack.sv =====
// Start-word setup: clips the rectangle to the surface, packs the colour,
// and forms the first row's byte offset. Depends on cref_pkg.
module cref_clip_pack import cref_pkg::*; #(
    parameter int MAX_SURFACE_DIM = 4096
) (
    input  in_word_t                                 req,
    input  cfg_t                                     cfg,
    output logic                                     empty,
    output logic [$clog2(MAX_SURFACE_DIM+1)-1:0]     x0,
    output logic [$clog2(MAX_SURFACE_DIM+1)-1:0]     y0,
    output logic [$clog2(MAX_SURFACE_DIM+1)-1:0]     x1,
    output logic [$clog2(MAX_SURFACE_DIM+1)-1:0]     y1,
    output logic [OFFS_W-1:0]                        row_base,
    output logic [31:0]                              colour
);

    localparam int CW = $clog2(MAX_SURFACE_DIM + 1);
    localparam logic [CRD_W-1:0] MAX_DIM = CRD_W'(MAX_SURFACE_DIM);

    logic signed [CRD_W-1:0] left, top, x1_raw, y1_raw;
    logic signed [CRD_W-1:0] x0_s, y0_s, x1_s, y1_s, sw_s, sh_s;
    logic [CRD_W-1:0]        sw_u, sh_u;
    logic [CW+15:0]          prod;
    logic [7:0]              a, r, g, b;

    always_comb begin
        left   = CRD_W'(req.rect_left);
        top    = CRD_W'(req.rect_top);
        x1_raw = left + CRD_W'(req.rect_width);
        y1_raw = top + CRD_W'(req.rect_height);
        x0_s   = left[CRD_W-1] ? '0 : left;
        y0_s   = top[CRD_W-1] ? '0 : top;
        sw_u   = CRD_W'(cfg.surface_width);
        sh_u   = CRD_W'(cfg.surface_height);
        sw_s   = signed'((sw_u > MAX_DIM) ? MAX_DIM : sw_u);
        sh_s   = signed'((sh_u > MAX_DIM) ? MAX_DIM : sh_u);
        x1_s   = (x1_raw > sw_s) ? sw_s : x1_raw;
        y1_s   = (y1_raw > sh_s) ? sh_s : y1_raw;
        empty  = (x0_s >= x1_s) || (y0_s >= y1_s);
    end

    assign x0 = x0_s[CW-1:0];
    assign y0 = y0_s[CW-1:0];
    assign x1 = x1_s[CW-1:0];
    assign y1 = y1_s[CW-1:0];

    assign prod     = y0 * cfg.row_stride_bytes;
    assign row_base = OFFS_W'(prod);

    assign a = req.fill_colour[31:24];
    assign r = req.fill_colour[23:16];
    assign g = req.fill_colour[15:8];
    assign b = req.fill_colour[7:0];

    always_comb begin
        case (cfg.pixel_format)
            FMT_ARGB: colour = {a, r, g, b};
            FMT_XRGB: colour = {8'hff, r, g, b};
            FMT_BGRA: colour = {b, g, r, a};
            FMT_BGRX: colour = {b, g, r, 8'hff};
            default:  colour = req.fill_colour;
        endcase
    end

endmodule

// ===== hdl/clipped_rect_fill_engine.sv =====
// Top level of the clipped rectangle fill engine: span walker and output register.
// Depends on cref_pkg, cref_apb_regs, cref_clip_pack.
//
//  channel | handshake             | word
//  s_      | s_valid / s_ready     | in_word_t  (start or step request)
//  m_      | m_valid / m_ready     | out_word_t (one result per request)
//  apb     | psel/penable/pready   | 32-bit config register write/read
//
// One result per accepted word; a word is taken every cycle while s_ready is high.
// The clip/pack path (one 16-bit-by-coordinate multiply) settles between the
// input pins and the output register; the step adders run from the job registers.
// s_ready is low only while a result is held and m_ready is low.
// Synchronous active-low reset clears the job's active flag and the output valid flag.
module clipped_rect_fill_engine import cref_pkg::*; #(
    parameter int MAX_SURFACE_DIM = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int CW = $clog2(MAX_SURFACE_DIM + 1);

    cfg_t              cfg;
    logic              clip_empty;
    logic [CW-1:0]     clip_x0, clip_y0, clip_x1, clip_y1;
    logic [OFFS_W-1:0] clip_base;
    logic [31:0]       clip_colour;

    logic              active_reg, active_next;
    logic [CW-1:0]     x_reg, x_next;
    logic [CW-1:0]     y_reg, y_next;
    logic [CW-1:0]     start_x_reg, start_x_next;
    logic [CW-1:0]     end_x_reg, end_x_next;
    logic [CW-1:0]     end_y_reg, end_y_next;
    logic [OFFS_W-1:0] base_reg, base_next;
    logic [31:0]       colour_reg, colour_next;
    logic              m_valid_reg;
    out_word_t         m_data_reg, m_data_next;

    logic              accept;
    logic [CW:0]       x_inc, y_inc;

    cref_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cref_clip_pack #(
        .MAX_SURFACE_DIM (MAX_SURFACE_DIM)
    ) u_clip (
        .req      (s_data),
        .cfg      (cfg),
        .empty    (clip_empty),
        .x0       (clip_x0),
        .y0       (clip_y0),
        .x1       (clip_x1),
        .y1       (clip_y1),
        .row_base (clip_base),
        .colour   (clip_colour)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign x_inc = {1'b0, x_reg} + 1'b1;
    assign y_inc = {1'b0, y_reg} + 1'b1;

    always_comb begin
        active_next  = active_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        start_x_next = start_x_reg;
        end_x_next   = end_x_reg;
        end_y_next   = end_y_reg;
        base_next    = base_reg;
        colour_next  = colour_reg;
        m_data_next  = '0;

        if (s_data.req_type == REQ_START) begin
            if (clip_empty) begin
                active_next        = 1'b0;
                m_data_next.status = ST_EMPTY;
            end else begin
                active_next        = 1'b1;
                x_next             = clip_x0;
                y_next             = clip_y0;
                start_x_next       = clip_x0;
                end_x_next         = clip_x1;
                end_y_next         = clip_y1;
                base_next          = clip_base;
                colour_next        = clip_colour;
                m_data_next.status = active_reg ? ST_RESTART : ST_OK;
            end
        end else if (!active_reg) begin
            m_data_next.status = ST_IDLE;
        end else begin
            m_data_next.write_valid = 1'b1;
            m_data_next.byte_offset = base_reg + (OFFS_W'(x_reg) << BPP_SHIFT);
            m_data_next.pixel_data  = colour_reg;
            m_data_next.status      = ST_OK;
            x_next                  = x_inc[CW-1:0];
            if (x_inc >= {1'b0, end_x_reg}) begin
                x_next    = start_x_reg;
                y_next    = y_inc[CW-1:0];
                base_next = base_reg + OFFS_W'(cfg.row_stride_bytes);
                if (y_inc >= {1'b0, end_y_reg}) begin
                    m_data_next.last = 1'b1;
                    active_next      = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            active_reg  <= active_next;
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg       <= x_next;
            y_reg       <= y_next;
            start_x_reg <= start_x_next;
            end_x_reg   <= end_x_next;
            end_y_reg   <= end_y_next;
            base_reg    <= base_next;
            colour_reg  <= colour_next;
            m_data_reg  <= m_data_next;
        end
    end

endmodule
